### rtl/psa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg: shared definitions of the partitioned slot allocator
// Geometry, field widths, status codes, controller states and the control
// bundle that drives one pool of key cells.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int ROWS_PER_CLASS = 2;
  localparam int SLOT_COLUMNS   = 10;
  localparam int KEY_BITS       = 16;

  localparam int POOL_SLOTS = ROWS_PER_CLASS * SLOT_COLUMNS;

  localparam int COL_W  = (SLOT_COLUMNS > 1) ? $clog2(SLOT_COLUMNS) : 1;
  localparam int ROWR_W = (ROWS_PER_CLASS > 1) ? $clog2(ROWS_PER_CLASS) : 1;

  localparam int IN_KEY_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int ROW_OUT_W = 2;
  localparam int COL_OUT_W = 4;
  localparam int COUNT_W   = 5;
  localparam int ALL_W     = 6;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE    = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2,
    STAT_ZERO    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic                shift;
    logic                arm;
    logic [KEY_BITS-1:0] want;
    logic [KEY_BITS-1:0] new_key;
  } pool_ctl_t;

endpackage

### rtl/psa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_if: request and response channels of the slot allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface psa_req_if;
  import psa_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic                vehicle_class;
  logic [IN_KEY_W-1:0] vehicle_key;

  modport source (output valid, req_type, vehicle_class, vehicle_key, input ready);
  modport sink (input valid, req_type, vehicle_class, vehicle_key, output ready);
endinterface

interface psa_rsp_if;
  import psa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [ROW_OUT_W-1:0] slot_row;
  logic [COL_OUT_W-1:0] slot_column;
  logic [COUNT_W-1:0]   class0_total;
  logic [COUNT_W-1:0]   class1_total;
  logic [ALL_W-1:0]     all_total;

  modport source (output valid, status, slot_row, slot_column, class0_total,
                  class1_total, all_total, input ready);
  modport sink (input valid, status, slot_row, slot_column, class0_total,
                class1_total, all_total, output ready);
endinterface

### rtl/psa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_cell: one slot of a pool
// Holds one key and takes its neighbor's key whenever the pool rotates.
// ----------------------------------------------------------------------------
module psa_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift,
  input  logic [psa_pkg::KEY_BITS-1:0]  d,
  output logic [psa_pkg::KEY_BITS-1:0]  q
);
  import psa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

### rtl/psa_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pool: one class pool as a ring of key cells
// Each rotation step presents the head slot for comparison; the head key
// re-enters at the tail, replaced on the first match of a pass.
// ----------------------------------------------------------------------------
module psa_pool (
  input  logic               clk,
  input  logic               rst,
  input  psa_pkg::pool_ctl_t ctl,
  output logic               hit
);
  import psa_pkg::*;

  logic [KEY_BITS-1:0] key_q [POOL_SLOTS];
  logic [KEY_BITS-1:0] wrap;

  assign hit  = ctl.arm && (key_q[0] == ctl.want);
  assign wrap = hit ? ctl.new_key : key_q[0];

  for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
    logic [KEY_BITS-1:0] d;

    if (i == POOL_SLOTS - 1) begin : g_tail
      assign d = wrap;
    end else begin : g_body
      assign d = key_q[i+1];
    end

    psa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (ctl.shift),
      .d     (d),
      .q     (key_q[i])
    );
  end

endmodule

### rtl/partitioned_slot_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_slot_allocator_unit: first-fit slot allocator with key lookup
// Two pools of key cells; allocate takes the first free slot of a pool,
// release frees the first slot holding the key. Occupancy per pool is kept.
// ----------------------------------------------------------------------------
//   channel   direction   beat contents
//   req       in          req_type, vehicle_class, vehicle_key
//   rsp       out         status, slot_row, slot_column, class totals
//
// A request with a nonzero key makes one full rotation of the selected pool's
// cell ring, stepping one slot at a time, before it finishes.
// A request with a zero key skips the rotation and goes straight to finish.
// Reset clears every slot and both counts.
// The response register holds one result; a stalled rsp lets the next
// request be accepted and scanned, and only its final write waits.
// ----------------------------------------------------------------------------
module partitioned_slot_allocator_unit (
  input  logic      clk,
  input  logic      rst,
  psa_req_if.sink   req,
  psa_rsp_if.source rsp
);
  import psa_pkg::*;

  state_t state;
  state_t state_next;

  logic                req_kind;
  logic                req_cls;
  logic [KEY_BITS-1:0] req_key;
  logic                zero_key;
  logic                found;
  logic [ROWR_W-1:0]   hit_row;
  logic [COL_W-1:0]    hit_col;
  logic [ROWR_W-1:0]   row_cnt;
  logic [COL_W-1:0]    col_cnt;

  logic [COUNT_W-1:0] class0_count;
  logic [COUNT_W-1:0] class1_count;
  logic [COUNT_W-1:0] class0_count_next;
  logic [COUNT_W-1:0] class1_count_next;

  logic                accept;
  logic                scan_en;
  logic                finish;
  logic                last_slot;
  logic                hit;
  logic                hit0;
  logic                hit1;
  logic [KEY_BITS-1:0] key_in;
  pool_ctl_t           ctl0;
  pool_ctl_t           ctl1;
  status_t             status_new;
  logic [ROW_OUT_W-1:0] row_abs;

  assign key_in    = KEY_BITS'(req.vehicle_key);
  assign accept    = req.valid && req.ready;
  assign last_slot = (row_cnt == ROWR_W'(ROWS_PER_CLASS - 1)) &&
                     (col_cnt == COL_W'(SLOT_COLUMNS - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (key_in == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_slot) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    scan_en   = 1'b0;
    finish    = 1'b0;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_SCAN:   scan_en = 1'b1;
      S_FINISH: finish = !rsp.valid || rsp.ready;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    ctl0.shift   = scan_en && !req_cls;
    ctl0.arm     = !found;
    ctl0.want    = req_kind ? req_key : '0;
    ctl0.new_key = req_kind ? '0 : req_key;
    ctl1         = ctl0;
    ctl1.shift   = scan_en && req_cls;
  end

  psa_pool u_pool0 (
    .clk (clk),
    .rst (rst),
    .ctl (ctl0),
    .hit (hit0)
  );

  psa_pool u_pool1 (
    .clk (clk),
    .rst (rst),
    .ctl (ctl1),
    .hit (hit1)
  );

  assign hit = req_cls ? hit1 : hit0;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req.req_type;
      req_cls  <= req.vehicle_class;
      req_key  <= key_in;
      zero_key <= (key_in == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (accept) begin
      found   <= 1'b0;
      row_cnt <= '0;
      col_cnt <= '0;
    end else if (scan_en) begin
      if (hit) begin
        found   <= 1'b1;
        hit_row <= row_cnt;
        hit_col <= col_cnt;
      end
      if (col_cnt == COL_W'(SLOT_COLUMNS - 1)) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    class0_count_next = class0_count;
    class1_count_next = class1_count;
    if (zero_key) begin
      status_new = STAT_ZERO;
    end else if (found) begin
      status_new = STAT_DONE;
      if (req_cls) begin
        class1_count_next = req_kind ? class1_count - 1'b1 : class1_count + 1'b1;
      end else begin
        class0_count_next = req_kind ? class0_count - 1'b1 : class0_count + 1'b1;
      end
    end else begin
      status_new = req_kind ? STAT_MISSING : STAT_FULL;
    end
    row_abs = ROW_OUT_W'(int'(req_cls) * ROWS_PER_CLASS + int'(hit_row));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      class0_count <= '0;
      class1_count <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      if (finish) begin
        class0_count <= class0_count_next;
        class1_count <= class1_count_next;
        rsp.valid    <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp.status       <= status_new;
      rsp.slot_row     <= (status_new == STAT_DONE) ? row_abs : '0;
      rsp.slot_column  <= (status_new == STAT_DONE) ? COL_OUT_W'(hit_col) : '0;
      rsp.class0_total <= class0_count_next;
      rsp.class1_total <= class1_count_next;
      rsp.all_total    <= ALL_W'(class0_count_next) + ALL_W'(class1_count_next);
    end
  end

  a_busy_after_accept : assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request accepted while a request was in progress");

  a_fail_position_zero : assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.status != STAT_DONE)) |->
      (rsp.slot_row == '0 && rsp.slot_column == '0))
    else $error("failed request reports a slot position");

  a_total_sum : assert property (@(posedge clk) disable iff (rst)
    rsp.valid |->
      (rsp.all_total == ALL_W'(rsp.class0_total) + ALL_W'(rsp.class1_total)))
    else $error("overall total differs from the sum of the pool totals");

  a_scan_one_pass : assert property (@(posedge clk) disable iff (rst)
    (scan_en && last_slot) |=> (state == S_FINISH && row_cnt == '0 && col_cnt == '0))
    else $error("pool scan did not end after one full rotation");

endmodule

### dv/partitioned_slot_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_slot_allocator_unit_tb: self-checking bench of the slot allocator
// Drives allocate and release requests over the request channel and tracks
// the slot table and the pool occupancy in a scoreboard. Every response beat
// is compared field by field with the oldest predicted result. Both channels
// idle in random bursts until a final quiet phase; the response side holds off
// once for a long stretch so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
import psa_pkg::*;

typedef struct packed {
  status_t              status;
  logic [ROW_OUT_W-1:0] slot_row;
  logic [COL_OUT_W-1:0] slot_column;
  logic [COUNT_W-1:0]   class0_total;
  logic [COUNT_W-1:0]   class1_total;
  logic [ALL_W-1:0]     all_total;
} alloc_result_t;

localparam logic REQ_ALLOC   = 1'b0;
localparam logic REQ_RELEASE = 1'b1;

class allocation_scoreboard;
  logic [KEY_BITS-1:0] slot_keys [2*POOL_SLOTS];
  logic [COUNT_W-1:0]  pool_count [2];
  alloc_result_t       pending_results [$];
  int                  failures;
  int                  reported;

  function new();
    foreach (slot_keys[i]) slot_keys[i] = '0;
    pool_count[0] = '0;
    pool_count[1] = '0;
    failures = 0;
    reported = 0;
  endfunction

  function void note_request(logic kind, logic cls, logic [IN_KEY_W-1:0] raw_key);
    alloc_result_t       res;
    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] want;
    int                  base;
    int                  idx;
    key  = raw_key[KEY_BITS-1:0];
    base = cls * POOL_SLOTS;
    idx  = POOL_SLOTS;
    res  = '0;
    res.status = STAT_DONE;
    if (key == '0) begin
      res.status = STAT_ZERO;
    end else begin
      want = (kind == REQ_ALLOC) ? '0 : key;
      for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
        if (slot_keys[base + i] == want) idx = i;
      end
      if (idx == POOL_SLOTS) begin
        if (kind == REQ_ALLOC) res.status = STAT_FULL;
        else res.status = STAT_MISSING;
      end else begin
        if (kind == REQ_ALLOC) begin
          slot_keys[base + idx] = key;
          pool_count[cls] = pool_count[cls] + 1'b1;
        end else begin
          slot_keys[base + idx] = '0;
          pool_count[cls] = pool_count[cls] - 1'b1;
        end
        res.slot_row    = ROW_OUT_W'(int'(cls) * ROWS_PER_CLASS + idx / SLOT_COLUMNS);
        res.slot_column = COL_OUT_W'(idx % SLOT_COLUMNS);
      end
    end
    res.class0_total = pool_count[0];
    res.class1_total = pool_count[1];
    res.all_total    = ALL_W'(pool_count[0]) + ALL_W'(pool_count[1]);
    pending_results.push_back(res);
  endfunction

  function void check_response(alloc_result_t got);
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      failures++;
      if (reported < 10) begin
        reported++;
        $display("Unexpected response beat: status=%0d row=%0d col=%0d c0=%0d c1=%0d all=%0d",
                 got.status, got.slot_row, got.slot_column, got.class0_total,
                 got.class1_total, got.all_total);
      end
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status || got.slot_row !== want.slot_row ||
          got.slot_column !== want.slot_column ||
          got.class0_total !== want.class0_total ||
          got.class1_total !== want.class1_total || got.all_total !== want.all_total) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("Mismatch: expected status=%0d row=%0d col=%0d c0=%0d c1=%0d all=%0d",
                   want.status, want.slot_row, want.slot_column, want.class0_total,
                   want.class1_total, want.all_total);
          $display("          actual   status=%0d row=%0d col=%0d c0=%0d c1=%0d all=%0d",
                   got.status, got.slot_row, got.slot_column, got.class0_total,
                   got.class1_total, got.all_total);
        end
      end
    end
  endfunction
endclass

module partitioned_slot_allocator_unit_tb;
  localparam int RANDOM_ITEMS = 1130;
  localparam int QUIET_ITEMS  = 100;
  localparam int LONG_HOLD    = 300;

  logic clk;
  logic rst;
  bit   quiet;
  bit   hold_request;

  psa_req_if req_ch ();
  psa_rsp_if rsp_ch ();

  allocation_scoreboard sb;

  partitioned_slot_allocator_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_request(logic kind, logic cls, logic [IN_KEY_W-1:0] key);
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= kind;
    req_ch.vehicle_class <= cls;
    req_ch.vehicle_key   <= key;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(kind, cls, key);
    if (!quiet && $urandom_range(0, 99) < 25) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.status       = status_t'(rsp_ch.status);
      got.slot_row     = rsp_ch.slot_row;
      got.slot_column  = rsp_ch.slot_column;
      got.class0_total = rsp_ch.class0_total;
      got.class1_total = rsp_ch.class1_total;
      got.all_total    = rsp_ch.all_total;
      sb.check_response(got);
    end
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    int                  alloc_pct;
    int                  roll;
    logic                kind;
    logic                cls;
    logic [IN_KEY_W-1:0] key;
    logic [KEY_BITS-1:0] stored [$];

    sb = new();
    quiet = 1'b0;
    hold_request = 1'b0;
    alloc_pct = 50;
    rst <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_ALLOC;
    req_ch.vehicle_class <= 1'b0;
    req_ch.vehicle_key   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Zero keys, absent keys, duplicates and cross-pool lookups.
    send_request(REQ_ALLOC,   1'b0, 16'h0000);
    send_request(REQ_RELEASE, 1'b1, 16'h0000);
    send_request(REQ_RELEASE, 1'b0, 16'h1234);
    send_request(REQ_ALLOC,   1'b0, 16'hFFFF);
    send_request(REQ_ALLOC,   1'b0, 16'hFFFF);
    send_request(REQ_ALLOC,   1'b1, 16'h0001);
    send_request(REQ_ALLOC,   1'b1, 16'h8000);
    send_request(REQ_RELEASE, 1'b1, 16'hFFFF);
    send_request(REQ_RELEASE, 1'b0, 16'hFFFF);
    send_request(REQ_ALLOC,   1'b0, 16'h5555);
    send_request(REQ_RELEASE, 1'b0, 16'hFFFF);
    send_request(REQ_RELEASE, 1'b0, 16'hFFFF);
    send_request(REQ_ALLOC,   1'b1, 16'hAAAA);
    send_request(REQ_RELEASE, 1'b1, 16'h0001);
    send_request(REQ_RELEASE, 1'b1, 16'h8000);
    send_request(REQ_RELEASE, 1'b1, 16'hAAAA);
    send_request(REQ_RELEASE, 1'b0, 16'h5555);
    send_request(REQ_RELEASE, 1'b0, 16'h5555);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 85;
          1: alloc_pct = 50;
          default: alloc_pct = 15;
        endcase
      end
      if (n == 350) hold_request = 1'b1;
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      kind = ($urandom_range(0, 99) < alloc_pct) ? REQ_ALLOC : REQ_RELEASE;
      cls  = 1'($urandom_range(0, 1));
      stored.delete();
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (sb.slot_keys[cls * POOL_SLOTS + i] != '0)
          stored.push_back(sb.slot_keys[cls * POOL_SLOTS + i]);
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) key = '0;
      else if (roll < 30) key = IN_KEY_W'($urandom());
      else if (kind == REQ_RELEASE && roll < 80 && stored.size() > 0)
        key = stored[$urandom_range(0, stored.size() - 1)];
      else key = IN_KEY_W'($urandom_range(1, 12));
      send_request(kind, cls, key);
    end
    req_ch.valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
